// ===== hw/rtl/rfd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package rfd_pkg;

  // Frame layout.
  localparam int MAX_FRAME_BYTES = 256;
  localparam int HEADER_BYTES    = 7;
  localparam int CRC_BYTES       = 2;
  localparam int MIN_FRAME_BYTES = HEADER_BYTES + CRC_BYTES;

  // Header byte positions that the checks or the status item single out.
  localparam int HDR_KIND    = 1;
  localparam int HDR_SEQ_HI  = 4;
  localparam int HDR_SEQ_LO  = 5;
  localparam int HDR_TYPE    = 6;

  // Widths that follow from the layout.
  localparam int CNT_W     = $clog2(MAX_FRAME_BYTES + 1);
  localparam int CMP_W     = (CNT_W > 8) ? CNT_W : 8;
  localparam int HDR_IDX_W = $clog2(HEADER_BYTES);

  // CRC-16/CCITT-FALSE.
  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;

  // Command queue between front and back.
  localparam int CMD_DEPTH  = 2;
  localparam int CMD_PTR_W  = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1;
  localparam int CMD_CNT_W  = $clog2(CMD_DEPTH + 1);

  // Configuration port.
  localparam int PADDR_W   = 4;
  localparam int PDATA_W   = 32;
  localparam int TDATA_W   = 80;
  localparam int OUT_PAD_W = 5;

  typedef enum logic [1:0] {
    REG_CAPACITY = 2'd0,
    REG_KIND     = 2'd1,
    REG_TYPE     = 2'd2
  } reg_idx_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_SHORT    = 3'd1,
    ST_CRC      = 3'd2,
    ST_CAPACITY = 3'd3,
    ST_KIND     = 3'd4,
    ST_TYPE     = 3'd5,
    ST_LONG     = 3'd6
  } status_e;

  typedef enum logic {
    ITEM_PAYLOAD = 1'b0,
    ITEM_STATUS  = 1'b1
  } item_kind_e;

  typedef struct packed {
    logic [7:0] payload_capacity;
    logic [7:0] highest_kind;
    logic [7:0] highest_type;
  } cfg_t;

  // One classified input byte, as the front hands it to the back.
  typedef struct packed {
    logic [7:0]           old_byte;    // byte leaving the delay line
    logic                 feed_crc;
    logic                 emit_pay;
    logic [7:0]           new_byte;    // byte just received
    logic                 hdr_wr;
    logic [HDR_IDX_W-1:0] hdr_idx;
    logic                 last;
    logic                 overflow;
    logic                 short_frame;
    logic                 over_cap;
    logic [15:0]          rx_crc;
    logic [7:0]           plen;
  } cmd_t;

  typedef struct packed {
    item_kind_e  item_kind;
    logic [7:0]  payload_byte;
    status_e     status;
    logic [7:0]  version;
    logic [7:0]  frame_kind;
    logic [7:0]  flag_bits;
    logic [7:0]  reserved_byte;
    logic [15:0] sequence_number;
    logic [7:0]  message_type;
    logic [7:0]  payload_length;
  } item_t;

  // Feed one byte into the CRC, MSB first.
  function automatic logic [15:0] crc16_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/radio_frame_decoder_crc16.sv =====
// A result reaches the master side through the command queue entry and the output
// register; the status after a payload byte waits in the pending slot behind it.
// Throughput: one byte per cycle while the master side accepts and no status is
// pending, set by the bytewise CRC step in the back end; a final byte that also
// releases a payload byte gives two items. Reset: asynchronous, active low;
// configuration registers return to 255; frame state is cleared at once, no pass needed.
`timescale 1ns / 1ps
`default_nettype none

module radio_frame_decoder_crc16 (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // APB-style configuration port
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [rfd_pkg::PADDR_W-1:0]   paddr,
  input  wire logic [rfd_pkg::PDATA_W-1:0]   pwdata,
  output logic      [rfd_pkg::PDATA_W-1:0]   prdata,
  output logic                               pready,
  // Raw frame bytes
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  input  wire logic [7:0]                    s_axis_tdata,  // data_byte[7:0]
  input  wire logic                          s_axis_tlast,  // last_byte
  // Payload and status items
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  // payload_byte[7:0], status[10:8], version[18:11], frame_kind[26:19],
  // flag_bits[34:27], reserved_byte[42:35], sequence_number[58:43],
  // message_type[66:59], payload_length[74:67], zero[79:75]
  output logic      [rfd_pkg::TDATA_W-1:0]   m_axis_tdata,
  output logic                               m_axis_tuser   // item_kind
);
  import rfd_pkg::*;

  cfg_t  cfg_q;
  logic  cfg_wr;
  logic  push, q_full, cmd_valid, pop;
  cmd_t  cmd_in, cmd_head;
  item_t item;

  // Configuration registers.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.payload_capacity <= 8'hFF;
      cfg_q.highest_kind     <= 8'hFF;
      cfg_q.highest_type     <= 8'hFF;
    end else if (cfg_wr) begin
      case (reg_idx_e'(paddr[3:2]))
        REG_CAPACITY: cfg_q.payload_capacity <= pwdata[7:0];
        REG_KIND:     cfg_q.highest_kind     <= pwdata[7:0];
        REG_TYPE:     cfg_q.highest_type     <= pwdata[7:0];
        default:      ;
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    case (reg_idx_e'(paddr[3:2]))
      REG_CAPACITY: prdata = PDATA_W'(cfg_q.payload_capacity);
      REG_KIND:     prdata = PDATA_W'(cfg_q.highest_kind);
      REG_TYPE:     prdata = PDATA_W'(cfg_q.highest_type);
      default:      prdata = '0;
    endcase
  end

  rfd_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .s_data_i  (s_axis_tdata),
    .s_last_i  (s_axis_tlast),
    .q_full_i  (q_full),
    .push_o    (push),
    .cmd_o     (cmd_in)
  );

  rfd_cmd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (cmd_in),
    .full_o  (q_full),
    .valid_o (cmd_valid),
    .pop_i   (pop),
    .cmd_o   (cmd_head)
  );

  rfd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd_head),
    .pop_o       (pop),
    .m_valid_o   (m_axis_tvalid),
    .m_ready_i   (m_axis_tready),
    .item_o      (item)
  );

  // Pack the result item onto the master side.
  assign m_axis_tuser = item.item_kind;
  assign m_axis_tdata = {{OUT_PAD_W{1'b0}}, item.payload_length, item.message_type,
                         item.sequence_number, item.reserved_byte, item.flag_bits,
                         item.frame_kind, item.version, item.status, item.payload_byte};

endmodule

`default_nettype wire

// ===== hw/rtl/rfd_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rfd_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire rfd_pkg::cfg_t cfg_i,
  input  wire logic          s_valid_i,
  output logic               s_ready_o,
  input  wire logic [7:0]    s_data_i,
  input  wire logic          s_last_i,
  input  wire logic          q_full_i,
  output logic               push_o,
  output rfd_pkg::cmd_t      cmd_o
);
  import rfd_pkg::*;

  logic [CNT_W-1:0] cnt_q, cnt_d, cnt_after;
  logic             ovf_q, ovf_d;
  logic [7:0]       d0_q, d0_d, d1_q, d1_d;
  logic             full_frame;
  logic [CMP_W-1:0] pos_ext, cap_ext, pl;

  assign s_ready_o = !q_full_i;
  assign push_o    = s_valid_i && !q_full_i;

  // Classify the incoming byte by its place in the frame.
  always_comb begin
    full_frame = (cnt_q >= CNT_W'(MAX_FRAME_BYTES));
    cnt_after  = full_frame ? cnt_q : cnt_q + 1'b1;
    pos_ext    = CMP_W'(cnt_q);
    cap_ext    = CMP_W'(cfg_i.payload_capacity);
    pl         = CMP_W'(cnt_after) - CMP_W'(MIN_FRAME_BYTES);

    cmd_o.old_byte    = d1_q;
    cmd_o.new_byte    = s_data_i;
    cmd_o.feed_crc    = !full_frame && (cnt_q >= CNT_W'(CRC_BYTES));
    cmd_o.emit_pay    = !full_frame && (pos_ext >= CMP_W'(MIN_FRAME_BYTES)) &&
                        ((pos_ext - CMP_W'(MIN_FRAME_BYTES)) < cap_ext);
    cmd_o.hdr_wr      = !full_frame && (cnt_q < CNT_W'(HEADER_BYTES));
    cmd_o.hdr_idx     = cnt_q[HDR_IDX_W-1:0];
    cmd_o.last        = s_last_i;
    cmd_o.overflow    = ovf_q || full_frame;
    cmd_o.short_frame = (cnt_after < CNT_W'(MIN_FRAME_BYTES));
    cmd_o.over_cap    = (pl > cap_ext);
    cmd_o.rx_crc      = full_frame ? {d1_q, d0_q} : {d0_q, s_data_i};
    if (cmd_o.overflow || cmd_o.short_frame) begin
      cmd_o.plen = 8'h00;
    end else if (pl > CMP_W'(8'hFF)) begin
      cmd_o.plen = 8'hFF;
    end else begin
      cmd_o.plen = pl[7:0];
    end
  end

  // Frame position, overflow mark and two-byte delay line.
  always_comb begin
    cnt_d = cnt_q;
    ovf_d = ovf_q;
    d0_d  = d0_q;
    d1_d  = d1_q;
    if (push_o) begin
      if (s_last_i) begin
        cnt_d = '0;
        ovf_d = 1'b0;
        d0_d  = 8'h00;
        d1_d  = 8'h00;
      end else if (full_frame) begin
        ovf_d = 1'b1;
      end else begin
        cnt_d = cnt_after;
        d1_d  = d0_q;
        d0_d  = s_data_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      ovf_q <= 1'b0;
      d0_q  <= 8'h00;
      d1_q  <= 8'h00;
    end else begin
      cnt_q <= cnt_d;
      ovf_q <= ovf_d;
      d0_q  <= d0_d;
      d1_q  <= d1_d;
    end
  end

  // The byte count never runs past the frame store.
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(MAX_FRAME_BYTES))
    else $error("front byte count beyond frame store");

endmodule

`default_nettype wire

// ===== hw/rtl/rfd_cmd_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rfd_cmd_fifo (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire rfd_pkg::cmd_t cmd_i,
  output logic               full_o,
  output logic               valid_o,
  input  wire logic          pop_i,
  output rfd_pkg::cmd_t      cmd_o
);
  import rfd_pkg::*;

  cmd_t                 mem_q [CMD_DEPTH];
  logic [CMD_PTR_W-1:0] wr_q, rd_q;
  logic [CMD_CNT_W-1:0] cnt_q;
  logic                 do_push, do_pop;

  assign full_o  = (cnt_q == CMD_CNT_W'(CMD_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign cmd_o   = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // Pointer and fill count bookkeeping.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == CMD_PTR_W'(CMD_DEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= (rd_q == CMD_PTR_W'(CMD_DEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= cmd_i;
    end
  end

  a_cnt_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CMD_CNT_W'(CMD_DEPTH))
    else $error("command queue fill count beyond depth");

endmodule

`default_nettype wire

// ===== hw/rtl/rfd_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rfd_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire rfd_pkg::cfg_t cfg_i,
  input  wire logic          cmd_valid_i,
  input  wire rfd_pkg::cmd_t cmd_i,
  output logic               pop_o,
  output logic               m_valid_o,
  input  wire logic          m_ready_i,
  output rfd_pkg::item_t     item_o
);
  import rfd_pkg::*;

  logic [15:0] crc_q, crc_n;
  logic [7:0]  hdr_q [HEADER_BYTES];
  logic [7:0]  hdr_n [HEADER_BYTES];
  logic        out_valid_q, pend_valid_q;
  item_t       out_q, pend_q;
  item_t       pay_item, stat_item;
  logic        out_ld;

  assign out_ld    = !out_valid_q || m_ready_i;
  assign pop_o     = out_ld && !pend_valid_q && cmd_valid_i;
  assign m_valid_o = out_valid_q;
  assign item_o    = out_q;

  // Running CRC and header capture for the command at the queue head.
  always_comb begin
    crc_n = cmd_i.feed_crc ? crc16_feed(crc_q, cmd_i.old_byte) : crc_q;
    for (int i = 0; i < HEADER_BYTES; i++) begin
      if (cmd_i.hdr_wr && (cmd_i.hdr_idx == HDR_IDX_W'(i))) begin
        hdr_n[i] = cmd_i.new_byte;
      end else begin
        hdr_n[i] = hdr_q[i];
      end
    end
  end

  // Build the payload item and the end-of-frame status item.
  always_comb begin
    pay_item              = '0;
    pay_item.item_kind    = ITEM_PAYLOAD;
    pay_item.payload_byte = cmd_i.old_byte;

    stat_item                 = '0;
    stat_item.item_kind       = ITEM_STATUS;
    stat_item.version         = hdr_n[0];
    stat_item.frame_kind      = hdr_n[HDR_KIND];
    stat_item.flag_bits       = hdr_n[2];
    stat_item.reserved_byte   = hdr_n[3];
    stat_item.sequence_number = {hdr_n[HDR_SEQ_HI], hdr_n[HDR_SEQ_LO]};
    stat_item.message_type    = hdr_n[HDR_TYPE];
    stat_item.payload_length  = cmd_i.plen;
    if (cmd_i.overflow) begin
      stat_item.status = ST_LONG;
    end else if (cmd_i.short_frame) begin
      stat_item.status = ST_SHORT;
    end else if (cmd_i.rx_crc != crc_n) begin
      stat_item.status = ST_CRC;
    end else if (cmd_i.over_cap) begin
      stat_item.status = ST_CAPACITY;
    end else if (hdr_n[HDR_KIND] > cfg_i.highest_kind) begin
      stat_item.status = ST_KIND;
    end else if (hdr_n[HDR_TYPE] > cfg_i.highest_type) begin
      stat_item.status = ST_TYPE;
    end else begin
      stat_item.status = ST_OK;
    end
  end

  // Output register control and frame state; a status item that follows a
  // payload item on the same byte waits in the pending slot.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      pend_valid_q <= 1'b0;
      crc_q        <= CRC_INIT;
      for (int i = 0; i < HEADER_BYTES; i++) begin
        hdr_q[i] <= 8'h00;
      end
    end else begin
      if (out_ld) begin
        if (pend_valid_q) begin
          out_valid_q  <= 1'b1;
          pend_valid_q <= 1'b0;
        end else if (cmd_valid_i) begin
          out_valid_q  <= cmd_i.emit_pay || cmd_i.last;
          pend_valid_q <= cmd_i.emit_pay && cmd_i.last;
        end else begin
          out_valid_q <= 1'b0;
        end
      end
      if (pop_o) begin
        if (cmd_i.last) begin
          crc_q <= CRC_INIT;
          for (int i = 0; i < HEADER_BYTES; i++) begin
            hdr_q[i] <= 8'h00;
          end
        end else begin
          crc_q <= crc_n;
          for (int i = 0; i < HEADER_BYTES; i++) begin
            hdr_q[i] <= hdr_n[i];
          end
        end
      end
    end
  end

  // Result payload registers.
  always_ff @(posedge clk_i) begin
    if (out_ld) begin
      if (pend_valid_q) begin
        out_q <= pend_q;
      end else if (cmd_valid_i) begin
        out_q  <= cmd_i.emit_pay ? pay_item : stat_item;
        pend_q <= stat_item;
      end
    end
  end

  a_pend_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_valid_q |-> out_valid_q)
    else $error("pending status without a result in the output register");

  a_pend_is_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_valid_q |-> (pend_q.item_kind == ITEM_STATUS))
    else $error("pending slot holds a payload item");

  a_pay_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_q.item_kind == ITEM_PAYLOAD)) |->
    ((out_q.status == ST_OK) && (out_q.payload_length == 8'h00)))
    else $error("payload item carries status fields");

endmodule

`default_nettype wire
